/* sv/gbd_pkg.sv */
// ============================================================================
// gbd_pkg
// Shared types, codes and helpers for the bulletin deframer.
// ============================================================================
package gbd_pkg;

    localparam int HDR_DEPTH = 32;
    localparam int HDR_AW    = $clog2(HDR_DEPTH);

    // heading positions
    localparam logic [4:0] PH_LOOK   = 5'd23;   // first BBB lookahead byte
    localparam logic [4:0] PH_BBB_SP = 5'd26;   // space after BBB
    localparam logic [4:0] PH_BODY   = 5'd27;   // heading done

    // result kinds
    localparam logic [2:0] K_HDR_OK  = 3'd0;
    localparam logic [2:0] K_HDR_ERR = 3'd1;
    localparam logic [2:0] K_TEXT    = 3'd2;
    localparam logic [2:0] K_REP_END = 3'd3;
    localparam logic [2:0] K_BUL_END = 3'd4;

    // route classes
    localparam logic [1:0] R_SYNOP = 2'd0;
    localparam logic [1:0] R_BUOY  = 2'd1;
    localparam logic [1:0] R_AMDAR = 2'd2;
    localparam logic [1:0] R_NONE  = 2'd3;

    localparam logic [7:0] CH_STX   = 8'h01;
    localparam logic [7:0] CH_ETX   = 8'h03;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam int TDATA_W = 152;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  text_byte;
        logic [9:0]  seq_number;
        logic [47:0] heading_code;
        logic [31:0] centre_code;
        logic [6:0]  day_of_month;
        logic [6:0]  hour_of_day;
        logic [6:0]  minute_of_hour;
        logic [23:0] amend_code;
        logic        has_amend;
        logic [1:0]  route_class;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic              load;       // latch input byte
        logic              gen;        // build a result into staging
        logic [2:0]        kind;
        logic              src_buf;    // text from buffer, else commit char
        logic              use_space;  // commit char is the held space
        logic              has_amend;
        logic              buf_we;
        logic [HDR_AW-1:0] buf_addr;
        logic [HDR_AW-1:0] rd_idx;
        logic              flush;      // release staging as last of run
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_end;
        logic in_space;
        logic c_word;
        logic c_digit;
        logic c_space;
        logic c_eq;
        logic rb_eq;
        logic can_emit;
        logic out_free;
        logic stg_valid;
    } sts_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] b);
        return is_digit(b) || ((b >= 8'h41) && (b <= 8'h5A)) ||
               ((b >= 8'h61) && (b <= 8'h7A)) || (b == 8'h5F);
    endfunction

endpackage

/* sv/gbd_datapath.sv */
// ============================================================================
// gbd_datapath
// Heading buffer, result builder, staging and output registers.
// ============================================================================
module gbd_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gbd_pkg::cmd_t                cmd,
    output gbd_pkg::sts_t                sts,
    input  logic                         in_op,
    input  logic [7:0]                   in_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output gbd_pkg::result_t             out_res,
    output logic                         out_last
);
    import gbd_pkg::*;

    logic [7:0] buf_mem [HDR_DEPTH];
    logic [7:0] chr_reg, chr_next;
    result_t    stg_reg, stg_next, out_reg, out_next, res;
    logic       stg_valid_reg, stg_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_last_reg, out_last_next;
    logic [7:0] c, rb;
    logic       out_free;

    assign c  = cmd.use_space ? CH_SPACE : chr_reg;
    assign rb = buf_mem[cmd.rd_idx];

    function automatic logic [9:0] dval(input logic [7:0] b);
        return {2'b00, b - 8'h30};
    endfunction

    always_comb
    begin
        res             = '0;
        res.kind        = cmd.kind;
        res.route_class = R_NONE;
        if (cmd.kind == K_TEXT)
        begin
            res.text_byte = cmd.src_buf ? rb : c;
        end
        if (cmd.kind == K_HDR_OK)
        begin
            res.seq_number     = dval(buf_mem[0]) * 10'd100 + dval(buf_mem[1]) * 10'd10
                               + dval(buf_mem[2]);
            res.heading_code   = {buf_mem[4], buf_mem[5], buf_mem[6],
                                  buf_mem[7], buf_mem[8], buf_mem[9]};
            res.centre_code    = {buf_mem[11], buf_mem[12], buf_mem[13], buf_mem[14]};
            res.day_of_month   = 7'(dval(buf_mem[16]) * 10'd10 + dval(buf_mem[17]));
            res.hour_of_day    = 7'(dval(buf_mem[18]) * 10'd10 + dval(buf_mem[19]));
            res.minute_of_hour = 7'(dval(buf_mem[20]) * 10'd10 + dval(buf_mem[21]));
            res.has_amend      = cmd.has_amend;
            res.amend_code     = cmd.has_amend ? {buf_mem[23], buf_mem[24], buf_mem[25]}
                                               : 24'd0;
            if (buf_mem[4] == "S" &&
                (buf_mem[5] == "M" || buf_mem[5] == "N" || buf_mem[5] == "I"))
                res.route_class = R_SYNOP;
            else if (buf_mem[4] == "S" && buf_mem[5] == "S")
                res.route_class = R_BUOY;
            else if (buf_mem[4] == "U" && (buf_mem[5] == "D" || buf_mem[5] == "A"))
                res.route_class = R_AMDAR;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        chr_next       = cmd.load ? in_byte : chr_reg;
        stg_next       = stg_reg;
        stg_valid_next = stg_valid_reg;
        out_next       = out_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.gen)
        begin
            if (stg_valid_reg)
            begin
                out_next       = stg_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            stg_next       = res;
            stg_valid_next = 1'b1;
        end
        else if (cmd.flush && stg_valid_reg)
        begin
            out_next       = stg_reg;
            out_last_next  = 1'b1;
            out_valid_next = 1'b1;
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chr_reg      <= chr_next;
        stg_reg      <= stg_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (cmd.buf_we)
            buf_mem[cmd.buf_addr] <= c;
    end

    assign sts.in_end    = in_op || in_byte == CH_STX || in_byte == CH_ETX;
    assign sts.in_space  = in_byte == CH_CR || in_byte == CH_LF || in_byte == CH_SPACE;
    assign sts.c_word    = is_word(c);
    assign sts.c_digit   = is_digit(c);
    assign sts.c_space   = c == CH_SPACE;
    assign sts.c_eq      = c == CH_EQ;
    assign sts.rb_eq     = rb == CH_EQ;
    assign sts.can_emit  = !stg_valid_reg || out_free;
    assign sts.out_free  = out_free;
    assign sts.stg_valid = stg_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_last  = out_last_reg;

endmodule

/* sv/gbd_ctrl.sv */
// ============================================================================
// gbd_ctrl
// Sequencer: whitespace folding, heading match, replay and bulletin close.
// ============================================================================
module gbd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gbd_pkg::sts_t sts,
    output gbd_pkg::cmd_t cmd
);
    import gbd_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_COMMIT = 4'd1;
    localparam logic [3:0] S_EQ     = 4'd2;
    localparam logic [3:0] S_REPLAY = 4'd3;
    localparam logic [3:0] S_REPEQ  = 4'd4;
    localparam logic [3:0] S_END    = 4'd5;
    localparam logic [3:0] S_ENDRO  = 4'd6;
    localparam logic [3:0] S_ENDBE  = 4'd7;
    localparam logic [3:0] S_FLUSH  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [4:0] phase_reg, phase_next;
    logic [4:0] idx_reg, idx_next, stop_reg, stop_next;
    logic       sp_reg, sp_next, held_reg, held_next, ne_reg, ne_next;
    logic       ro_reg, ro_next, second_reg, second_next;
    logic       usp_reg, usp_next, inend_reg, inend_next;
    logic       pos_ok;
    logic [3:0] after_commit;

    assign in_ready = state_reg == S_IDLE;

    // character class expected at each heading position
    always_comb
    begin
        if (phase_reg == 5'd3 || phase_reg == 5'd10 || phase_reg == 5'd15 ||
            phase_reg == 5'd22)
            pos_ok = sts.c_space;
        else if ((phase_reg >= 5'd4 && phase_reg <= 5'd7) ||
                 (phase_reg >= 5'd11 && phase_reg <= 5'd14))
            pos_ok = sts.c_word;
        else
            pos_ok = sts.c_digit;
    end

    assign after_commit = second_reg ? S_COMMIT : S_FLUSH;

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        stop_next   = stop_reg;
        sp_next     = sp_reg;
        held_next   = held_reg;
        ne_next     = ne_reg;
        ro_next     = ro_reg;
        second_next = second_reg;
        usp_next    = usp_reg;
        inend_next  = inend_reg;
        cmd           = '0;
        cmd.kind      = K_TEXT;
        cmd.use_space = usp_reg;
        cmd.buf_addr  = phase_reg;
        cmd.rd_idx    = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.in_end)
                    begin
                        if (ne_reg)
                            state_next = S_END;
                        else
                        begin
                            sp_next    = 1'b1;
                            held_next  = 1'b0;
                            phase_next = '0;
                            ro_next    = 1'b0;
                        end
                    end
                    else if (sts.in_space)
                    begin
                        if (!sp_reg)
                            held_next = 1'b1;
                        sp_next = 1'b1;
                    end
                    else
                    begin
                        sp_next     = 1'b0;
                        held_next   = 1'b0;
                        usp_next    = held_reg;
                        second_next = held_reg;
                        ne_next     = 1'b1;
                        state_next  = S_COMMIT;
                    end
                end
            end
            S_COMMIT:
            begin
                second_next = 1'b0;
                usp_next    = 1'b0;
                if (phase_reg >= PH_BODY)
                begin
                    if (sts.can_emit)
                    begin
                        cmd.gen    = 1'b1;
                        ro_next    = 1'b1;
                        state_next = sts.c_eq ? S_EQ : after_commit;
                    end
                    else
                    begin
                        second_next = second_reg;
                        usp_next    = usp_reg;
                    end
                end
                else if (phase_reg < PH_LOOK && pos_ok)
                begin
                    cmd.buf_we = 1'b1;
                    phase_next = phase_reg + 5'd1;
                    state_next = after_commit;
                end
                else if (phase_reg >= PH_LOOK && phase_reg < PH_BBB_SP && sts.c_word)
                begin
                    cmd.buf_we = 1'b1;
                    phase_next = phase_reg + 5'd1;
                    state_next = after_commit;
                end
                else if (!sts.can_emit)
                begin
                    second_next = second_reg;
                    usp_next    = usp_reg;
                end
                else if (phase_reg == PH_BBB_SP && sts.c_space)
                begin
                    cmd.gen       = 1'b1;
                    cmd.kind      = K_HDR_OK;
                    cmd.has_amend = 1'b1;
                    phase_next    = PH_BODY;
                    state_next    = after_commit;
                end
                else
                begin
                    // mismatch, or no BBB: buffer the byte and replay
                    cmd.buf_we  = 1'b1;
                    cmd.gen     = 1'b1;
                    cmd.kind    = (phase_reg < PH_LOOK) ? K_HDR_ERR : K_HDR_OK;
                    idx_next    = (phase_reg < PH_LOOK) ? 5'd0 : PH_LOOK;
                    stop_next   = phase_reg + 5'd1;
                    phase_next  = PH_BODY;
                    inend_next  = 1'b0;
                    second_next = second_reg;
                    state_next  = S_REPLAY;
                end
            end
            S_EQ:
            begin
                if (sts.can_emit)
                begin
                    cmd.gen    = 1'b1;
                    cmd.kind   = K_REP_END;
                    ro_next    = 1'b0;
                    state_next = after_commit;
                end
            end
            S_REPLAY:
            begin
                if (idx_reg == stop_reg)
                begin
                    if (inend_reg)
                        state_next = S_ENDRO;
                    else
                    begin
                        second_next = 1'b0;
                        usp_next    = 1'b0;
                        state_next  = after_commit;
                    end
                end
                else if (sts.can_emit)
                begin
                    cmd.gen     = 1'b1;
                    cmd.src_buf = 1'b1;
                    ro_next     = 1'b1;
                    idx_next    = idx_reg + 5'd1;
                    if (sts.rb_eq)
                        state_next = S_REPEQ;
                end
            end
            S_REPEQ:
            begin
                if (sts.can_emit)
                begin
                    cmd.gen    = 1'b1;
                    cmd.kind   = K_REP_END;
                    ro_next    = 1'b0;
                    state_next = S_REPLAY;
                end
            end
            S_END:
            begin
                if (phase_reg >= PH_BODY)
                    state_next = S_ENDRO;
                else if (sts.can_emit)
                begin
                    cmd.gen    = 1'b1;
                    cmd.kind   = (phase_reg < PH_LOOK) ? K_HDR_ERR : K_HDR_OK;
                    idx_next   = (phase_reg < PH_LOOK) ? 5'd0 : PH_LOOK;
                    stop_next  = phase_reg;
                    inend_next = 1'b1;
                    state_next = S_REPLAY;
                end
            end
            S_ENDRO:
            begin
                if (!ro_reg)
                    state_next = S_ENDBE;
                else if (sts.can_emit)
                begin
                    cmd.gen    = 1'b1;
                    cmd.kind   = K_REP_END;
                    ro_next    = 1'b0;
                    state_next = S_ENDBE;
                end
            end
            S_ENDBE:
            begin
                if (sts.can_emit)
                begin
                    cmd.gen    = 1'b1;
                    cmd.kind   = K_BUL_END;
                    sp_next    = 1'b1;
                    held_next  = 1'b0;
                    ne_next    = 1'b0;
                    phase_next = '0;
                    ro_next    = 1'b0;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!sts.stg_valid || sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= '0;
            idx_reg    <= '0;
            stop_reg   <= '0;
            sp_reg     <= 1'b1;
            held_reg   <= 1'b0;
            ne_reg     <= 1'b0;
            ro_reg     <= 1'b0;
            second_reg <= 1'b0;
            usp_reg    <= 1'b0;
            inend_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            stop_reg   <= stop_next;
            sp_reg     <= sp_next;
            held_reg   <= held_next;
            ne_reg     <= ne_next;
            ro_reg     <= ro_next;
            second_reg <= second_next;
            usp_reg    <= usp_next;
            inend_reg  <= inend_next;
        end
    end

endmodule

/* sv/gts_bulletin_deframer.sv */
// ============================================================================
// gts_bulletin_deframer
// Splits a byte stream into bulletins and parses each abbreviated heading.
// ============================================================================
// Requests are taken one at a time: s_axis_tready is high only while idle.
//   Whitespace and the end of an empty bulletin give no result; any other
//   data byte is committed, after the held space if there is one, and a '='
//   that closes a report adds a report end. A heading mismatch replays the
//   buffered bytes, with a report end after each '='; a bulletin end first
//   replays an unfinished heading. Results pass staging, then the output register.
// Reset (rst_n, async, low): sequencer idle, no bulletin open, outputs empty.
module gts_bulletin_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // data_byte
    input  logic                          s_axis_tuser,  // opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // text_byte[7:0], seq_number[17:8], heading_code[65:18], centre_code[97:66],
    // day_of_month[104:98], hour_of_day[111:105], minute_of_hour[118:112],
    // amend_code[142:119], has_amend[143], route_class[145:144], zero pad
    output logic [gbd_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [2:0]                    m_axis_tuser,  // kind
    output logic                          m_axis_tlast   // last_of_run
);
    import gbd_pkg::*;

    cmd_t    cmd;
    sts_t    sts;
    result_t res;

    // sequencer: decides every result and buffer write
    gbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // buffer, result builder, one staging slot ahead of the output register
    gbd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {6'd0, res.route_class, res.has_amend, res.amend_code,
                           res.minute_of_hour, res.hour_of_day, res.day_of_month,
                           res.centre_code, res.heading_code, res.seq_number,
                           res.text_byte};

    // a new request is never taken while part of a run is still staged
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !sts.stg_valid)
        else $error("request accepted with a staged result");

    // a result is only built when staging can move on
    a_gen_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gen |-> sts.can_emit)
        else $error("result built without room");

    a_gen_flush: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.gen && cmd.flush))
        else $error("build and flush together");

endmodule
